### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/lcch_pkg.sv
// ----------------------------------------------------------------------------
// lcch_pkg
// Types, constants and helpers for the Lab centroid cell histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package lcch_pkg;

	localparam int NUM_CENTROIDS = 15;
	localparam int MAX_CELL_SIDE = 8;

	localparam int IDX_W      = 4;
	localparam int SIDE_W     = 4;
	localparam int PIX_W      = 8;
	localparam int COMP_W     = 12;
	localparam int FRAC_W     = COMP_W - PIX_W;
	localparam int SQ_W       = 2 * COMP_W;
	localparam int DIST_W     = SQ_W + 2;
	localparam int BIN_CNT_W  = 7;
	localparam int CELL_CNT_W = $clog2(MAX_CELL_SIDE * MAX_CELL_SIDE + 1);

	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [COMP_W-1:0]     comp_t;
	typedef logic [CELL_CNT_W-1:0] cell_cnt_t;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef struct packed {
		comp_t l;
		comp_t a;
		comp_t b;
	} centroid_t;

	typedef struct packed {
		logic vld;
		idx_t idx;
	} bin_word_t;

	function automatic cell_cnt_t cell_target(logic [SIDE_W-1:0] side);
		logic [SIDE_W-1:0] s;
		cell_cnt_t w;
		s = side;
		if (s == '0) begin
			s = SIDE_W'(1);
		end
		if (int'(s) > MAX_CELL_SIDE) begin
			s = SIDE_W'(MAX_CELL_SIDE);
		end
		w = CELL_CNT_W'(s);
		return CELL_CNT_W'(w * w);
	endfunction

	function automatic comp_t abs_diff(comp_t p, comp_t c);
		return (p >= c) ? comp_t'(p - c) : comp_t'(c - p);
	endfunction

endpackage

`default_nettype wire

### src/lcch_front.sv
// ----------------------------------------------------------------------------
// lcch_front
// Accepts words, keeps the centroid table and finds the nearest centroid
// of each pixel with one shared distance unit, one centroid per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcch_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               item_valid,
	output logic                              item_stall,
	input  wire                               cmd,
	input  wire  [3:0]                        centroid_slot,
	input  wire  [lcch_pkg::COMP_W-1:0]       centroid_l,
	input  wire  [lcch_pkg::COMP_W-1:0]       centroid_a,
	input  wire  [lcch_pkg::COMP_W-1:0]       centroid_b,
	input  wire  [lcch_pkg::PIX_W-1:0]        pixel_l,
	input  wire  [lcch_pkg::PIX_W-1:0]        pixel_a,
	input  wire  [lcch_pkg::PIX_W-1:0]        pixel_b,
	output lcch_pkg::bin_word_t               push,
	input  wire                               q_full
);

	typedef enum logic [3:0] {
		F_IDLE  = 4'b0001,
		F_SCAN  = 4'b0010,
		F_FLUSH = 4'b0100,
		F_PUSH  = 4'b1000
	} front_state_t;

	front_state_t                       state_q;
	lcch_pkg::centroid_t                tbl_q [lcch_pkg::NUM_CENTROIDS];
	lcch_pkg::centroid_t                pix_q;
	lcch_pkg::centroid_t                cent;
	lcch_pkg::idx_t                     scan_k_q;
	logic                               vld_s1;
	lcch_pkg::idx_t                     idx_s1;
	logic [lcch_pkg::SQ_W-1:0]          sq_l_s1;
	logic [lcch_pkg::SQ_W-1:0]          sq_a_s1;
	logic [lcch_pkg::SQ_W-1:0]          sq_b_s1;
	logic [lcch_pkg::DIST_W-1:0]        dist_sum;
	logic [lcch_pkg::DIST_W-1:0]        best_dist_q;
	lcch_pkg::idx_t                     best_idx_q;
	logic                               accept;
	logic                               is_load;
	lcch_pkg::comp_t                    dl;
	lcch_pkg::comp_t                    da;
	lcch_pkg::comp_t                    db;

	assign item_stall = (state_q != F_IDLE);
	assign accept     = item_valid && !item_stall;
	assign is_load    = (lcch_pkg::cmd_t'(cmd) == lcch_pkg::CMD_LOAD);

	assign cent = tbl_q[scan_k_q];
	assign dl   = lcch_pkg::abs_diff(pix_q.l, cent.l);
	assign da   = lcch_pkg::abs_diff(pix_q.a, cent.a);
	assign db   = lcch_pkg::abs_diff(pix_q.b, cent.b);
	assign dist_sum = lcch_pkg::DIST_W'(sq_l_s1) + lcch_pkg::DIST_W'(sq_a_s1)
	                + lcch_pkg::DIST_W'(sq_b_s1);

	assign push.vld = (state_q == F_PUSH);
	assign push.idx = best_idx_q;

	always_ff @(posedge clk) begin
		if (accept && is_load && (int'(centroid_slot) < lcch_pkg::NUM_CENTROIDS)) begin
			tbl_q[centroid_slot] <= '{l: centroid_l, a: centroid_a, b: centroid_b};
		end
		if (accept && !is_load) begin
			pix_q.l <= {pixel_l, {lcch_pkg::FRAC_W{1'b0}}};
			pix_q.a <= {pixel_a, {lcch_pkg::FRAC_W{1'b0}}};
			pix_q.b <= {pixel_b, {lcch_pkg::FRAC_W{1'b0}}};
		end
		idx_s1  <= scan_k_q;
		sq_l_s1 <= lcch_pkg::SQ_W'(dl) * lcch_pkg::SQ_W'(dl);
		sq_a_s1 <= lcch_pkg::SQ_W'(da) * lcch_pkg::SQ_W'(da);
		sq_b_s1 <= lcch_pkg::SQ_W'(db) * lcch_pkg::SQ_W'(db);
		if (vld_s1 && ((idx_s1 == '0) || (dist_sum < best_dist_q))) begin
			best_dist_q <= dist_sum;
			best_idx_q  <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			scan_k_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				F_IDLE: begin
					scan_k_q <= '0;
					if (accept && !is_load) begin
						state_q <= F_SCAN;
					end
				end
				F_SCAN: begin
					vld_s1   <= 1'b1;
					scan_k_q <= scan_k_q + 1'b1;
					if (int'(scan_k_q) == lcch_pkg::NUM_CENTROIDS - 1) begin
						state_q <= F_FLUSH;
					end
				end
				F_FLUSH: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/lcch_queue.sv
// ----------------------------------------------------------------------------
// lcch_queue
// Two-entry queue of winning centroid indices between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lcch_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lcch_pkg::bin_word_t  push,
	output logic                 full,
	output lcch_pkg::bin_word_t  pop,
	input  wire                  pop_ready
);

	lcch_pkg::idx_t   mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (cnt_q == 2'd2);
	assign pop.vld  = (cnt_q != 2'd0);
	assign pop.idx  = mem_q[rd_ptr_q];
	assign do_push  = push.vld && !full;
	assign do_pop   = pop.vld && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

`default_nettype wire

### src/lcch_back.sv
// ----------------------------------------------------------------------------
// lcch_back
// Counts hits per centroid, closes each cell and streams its histogram
// out through a registered output word.
// ----------------------------------------------------------------------------
`default_nettype none

module lcch_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [lcch_pkg::SIDE_W-1:0]       cell_side,
	input  lcch_pkg::bin_word_t               pop,
	output logic                              pop_ready,
	output logic                              bin_valid,
	input  wire                               bin_stall,
	output logic [lcch_pkg::IDX_W-1:0]        bin_index,
	output logic [lcch_pkg::BIN_CNT_W-1:0]    bin_count,
	output logic                              last_bin
);

	typedef enum logic [1:0] {
		B_ACCUM = 2'b01,
		B_EMIT  = 2'b10
	} back_state_t;

	back_state_t           state_q;
	lcch_pkg::cell_cnt_t   hit_q [lcch_pkg::NUM_CENTROIDS];
	lcch_pkg::cell_cnt_t   cell_cnt_q;
	lcch_pkg::cell_cnt_t   cnt_next;
	lcch_pkg::idx_t        emit_k_q;
	lcch_pkg::idx_t        addr;
	logic                  take;
	logic                  load_out;
	logic                  emit_last;

	assign pop_ready = (state_q == B_ACCUM);
	assign take      = pop.vld && pop_ready;
	assign load_out  = (state_q == B_EMIT) && (!bin_valid || !bin_stall);
	assign emit_last = (int'(emit_k_q) == lcch_pkg::NUM_CENTROIDS - 1);
	assign addr      = (state_q == B_EMIT) ? emit_k_q : pop.idx;
	assign cnt_next  = cell_cnt_q + 1'b1;

	always_ff @(posedge clk) begin
		if (load_out) begin
			bin_index <= emit_k_q;
			bin_count <= lcch_pkg::BIN_CNT_W'(hit_q[addr]);
			last_bin  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_ACCUM;
			cell_cnt_q <= '0;
			emit_k_q   <= '0;
			bin_valid  <= 1'b0;
			for (int i = 0; i < lcch_pkg::NUM_CENTROIDS; i++) begin
				hit_q[i] <= '0;
			end
		end else begin
			if (load_out) begin
				bin_valid <= 1'b1;
			end else if (!bin_stall) begin
				bin_valid <= 1'b0;
			end
			unique case (state_q)
				B_ACCUM: begin
					if (take) begin
						hit_q[addr] <= hit_q[addr] + 1'b1;
						if (cnt_next >= lcch_pkg::cell_target(cell_side)) begin
							cell_cnt_q <= '0;
							emit_k_q   <= '0;
							state_q    <= B_EMIT;
						end else begin
							cell_cnt_q <= cnt_next;
						end
					end
				end
				B_EMIT: begin
					if (load_out) begin
						hit_q[addr] <= '0;
						emit_k_q    <= emit_k_q + 1'b1;
						if (emit_last) begin
							state_q <= B_ACCUM;
						end
					end
				end
				default: begin
					state_q <= B_ACCUM;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### src/lab_centroid_cell_histogram_top.sv
// ----------------------------------------------------------------------------
// lab_centroid_cell_histogram_top
// Nearest-centroid classification of Lab pixels with a per-cell histogram.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall): cmd 0 loads centroid_slot with
// centroid_l/a/b; cmd 1 presents one Lab pixel. The shared distance unit
// visits one centroid per cycle, so a pixel holds the input through the
// scan of all NUM_CENTROIDS centroids, a flush and the push of its winner
// before the next word is taken. A two-entry queue carries winning indices
// to the counters. When cell_side squared pixels have been counted, the
// block emits one word per centroid on the output channel
// (bin_valid/bin_stall), bin_index 0 upward, last_bin on the final one,
// at most one word per cycle. While the receiver stalls, the output word
// holds and the counters wait; the front keeps working until the queue
// fills.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes cell_side;
// it is always ready. Values of 0 act as 1, above 8 as 8.
// Reset clears the histogram and pixel count and sets cell_side to 4; the
// centroid table is undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lab_centroid_cell_histogram_top (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               item_valid,
	output logic                              item_stall,
	input  wire                               cmd,
	input  wire  [3:0]                        centroid_slot,
	input  wire  [lcch_pkg::COMP_W-1:0]       centroid_l,
	input  wire  [lcch_pkg::COMP_W-1:0]       centroid_a,
	input  wire  [lcch_pkg::COMP_W-1:0]       centroid_b,
	input  wire  [lcch_pkg::PIX_W-1:0]        pixel_l,
	input  wire  [lcch_pkg::PIX_W-1:0]        pixel_a,
	input  wire  [lcch_pkg::PIX_W-1:0]        pixel_b,
	output logic                              bin_valid,
	input  wire                               bin_stall,
	output logic [lcch_pkg::IDX_W-1:0]        bin_index,
	output logic [lcch_pkg::BIN_CNT_W-1:0]    bin_count,
	output logic                              last_bin,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [lcch_pkg::SIDE_W-1:0]       cfg_data
);

	logic [lcch_pkg::SIDE_W-1:0] cell_side_q;
	lcch_pkg::bin_word_t         push;
	lcch_pkg::bin_word_t         pop;
	logic                        q_full;
	logic                        pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_side_q <= lcch_pkg::SIDE_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			cell_side_q <= cfg_data;
		end
	end

	lcch_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.centroid_slot (centroid_slot),
		.centroid_l    (centroid_l),
		.centroid_a    (centroid_a),
		.centroid_b    (centroid_b),
		.pixel_l       (pixel_l),
		.pixel_a       (pixel_a),
		.pixel_b       (pixel_b),
		.push          (push),
		.q_full        (q_full)
	);

	lcch_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop       (pop),
		.pop_ready (pop_ready)
	);

	lcch_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_side (cell_side_q),
		.pop       (pop),
		.pop_ready (pop_ready),
		.bin_valid (bin_valid),
		.bin_stall (bin_stall),
		.bin_index (bin_index),
		.bin_count (bin_count),
		.last_bin  (last_bin)
	);

endmodule

`default_nettype wire

### src/lcch_checker.sv
// ----------------------------------------------------------------------------
// lcch_checker
// Port-level checks of the Lab centroid cell histogram, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
`default_nettype none

module lcch_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               item_valid,
	input  wire                               item_stall,
	input  wire                               cmd,
	input  wire                               bin_valid,
	input  wire                               bin_stall,
	input  wire  [lcch_pkg::IDX_W-1:0]        bin_index,
	input  wire  [lcch_pkg::BIN_CNT_W-1:0]    bin_count,
	input  wire                               last_bin
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, bin_valid && bin_stall, bin_valid && $stable(bin_index) && $stable(bin_count) && $stable(last_bin), "output word changed while stalled")

	`ASSERT_IMPL(a_last_marks_top, clk, arst_n, bin_valid, last_bin == (32'(bin_index) == 32'(lcch_pkg::NUM_CENTROIDS - 1)), "last_bin not on the final centroid")

	`ASSERT_IMPL(a_count_range, clk, arst_n, bin_valid, 32'(bin_count) <= lcch_pkg::MAX_CELL_SIDE * lcch_pkg::MAX_CELL_SIDE, "bin count above cell size")

	`ASSERT_NEXT(a_pixel_busy, clk, arst_n, item_valid && !item_stall && cmd == lcch_pkg::CMD_PIXEL, item_stall, "front idle right after a pixel")

endmodule

bind lab_centroid_cell_histogram_top lcch_checker u_lcch_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_stall (item_stall),
	.cmd        (cmd),
	.bin_valid  (bin_valid),
	.bin_stall  (bin_stall),
	.bin_index  (bin_index),
	.bin_count  (bin_count),
	.last_bin   (last_bin)
);

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Lab centroid cell histogram. A scoreboard class
// keeps its own centroid palette and per-cell hit counts, predicts the bin
// words of every closed cell and checks the output channel word by word. The
// stimulus loads the palette and then runs phases of pixels at several cell
// sides. Both channels idle at random, and the receiver holds off once long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int CYCLE_LIMIT = 100000;
	localparam int SETTLE      = 2 * (lcch_pkg::NUM_CENTROIDS + 3) + 8;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		lcch_pkg::idx_t                 idx;
		logic [lcch_pkg::BIN_CNT_W-1:0] cnt;
		logic                           last;
	} hist_word_t;

	class cell_hist_board;
		lcch_pkg::centroid_t            palette[lcch_pkg::NUM_CENTROIDS];
		logic [lcch_pkg::BIN_CNT_W-1:0] hits[lcch_pkg::NUM_CENTROIDS];
		int unsigned                    cell_fill;
		logic [lcch_pkg::SIDE_W-1:0]    side;
		hist_word_t                     expected_bins[$];
		int                             errors;

		function new();
			foreach (palette[k]) begin
				palette[k] = '0;
				hits[k]    = '0;
			end
			cell_fill = 0;
			side      = lcch_pkg::SIDE_W'(4);
			errors    = 0;
		endfunction

		function void set_side(logic [lcch_pkg::SIDE_W-1:0] v);
			side = v;
		endfunction

		function int pending();
			return expected_bins.size();
		endfunction

		function void fail(string msg);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s", $time, msg);
			end
		endfunction

		function logic [lcch_pkg::SQ_W-1:0] sq_gap(lcch_pkg::comp_t p, lcch_pkg::comp_t c);
			logic [lcch_pkg::SQ_W-1:0] d;
			d = (p >= c) ? lcch_pkg::SQ_W'(p - c) : lcch_pkg::SQ_W'(c - p);
			return d * d;
		endfunction

		function lcch_pkg::idx_t nearest_centroid(logic [lcch_pkg::PIX_W-1:0] pl,
				logic [lcch_pkg::PIX_W-1:0] pa, logic [lcch_pkg::PIX_W-1:0] pb);
			lcch_pkg::comp_t             xl, xa, xb;
			logic [lcch_pkg::DIST_W-1:0] d, best_d;
			lcch_pkg::idx_t              best;
			xl     = {pl, {lcch_pkg::FRAC_W{1'b0}}};
			xa     = {pa, {lcch_pkg::FRAC_W{1'b0}}};
			xb     = {pb, {lcch_pkg::FRAC_W{1'b0}}};
			best   = '0;
			best_d = '0;
			for (int k = 0; k < lcch_pkg::NUM_CENTROIDS; k++) begin
				d = lcch_pkg::DIST_W'(sq_gap(xl, palette[k].l))
					+ lcch_pkg::DIST_W'(sq_gap(xa, palette[k].a))
					+ lcch_pkg::DIST_W'(sq_gap(xb, palette[k].b));
				if (k == 0 || d < best_d) begin
					best_d = d;
					best   = lcch_pkg::IDX_W'(k);
				end
			end
			return best;
		endfunction

		function void note_word(lcch_pkg::cmd_t c, lcch_pkg::idx_t slot,
				lcch_pkg::comp_t cl, lcch_pkg::comp_t ca, lcch_pkg::comp_t cb,
				logic [lcch_pkg::PIX_W-1:0] pl, logic [lcch_pkg::PIX_W-1:0] pa,
				logic [lcch_pkg::PIX_W-1:0] pb);
			lcch_pkg::idx_t win;
			int unsigned    eff;
			hist_word_t     w;
			if (c == lcch_pkg::CMD_LOAD) begin
				if (slot < lcch_pkg::NUM_CENTROIDS) begin
					palette[slot] = '{l: cl, a: ca, b: cb};
				end
				return;
			end
			win = nearest_centroid(pl, pa, pb);
			hits[win]++;
			cell_fill++;
			eff = (side == 0) ? 1 : (side > lcch_pkg::MAX_CELL_SIDE) ?
				lcch_pkg::MAX_CELL_SIDE : side;
			if (cell_fill >= eff * eff) begin
				for (int k = 0; k < lcch_pkg::NUM_CENTROIDS; k++) begin
					w.idx  = lcch_pkg::IDX_W'(k);
					w.cnt  = hits[k];
					w.last = (k == lcch_pkg::NUM_CENTROIDS - 1);
					expected_bins.insert(expected_bins.size(), w);
					hits[k] = '0;
				end
				cell_fill = 0;
			end
		endfunction

		function void check_bin(lcch_pkg::idx_t idx, logic [lcch_pkg::BIN_CNT_W-1:0] cnt,
				logic last);
			hist_word_t w;
			if (expected_bins.size() == 0) begin
				fail($sformatf("unexpected bin word: idx %0d count %0d last %0b",
					idx, cnt, last));
				return;
			end
			w = expected_bins.pop_front();
			if (w.idx !== idx || w.cnt !== cnt || w.last !== last) begin
				fail($sformatf("bin word mismatch: expected idx %0d count %0d last %0b, %s",
					w.idx, w.cnt, w.last,
					$sformatf("got idx %0d count %0d last %0b", idx, cnt, last)));
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           item_valid = 1'b0;
	logic                           item_stall;
	lcch_pkg::cmd_t                 cmd = lcch_pkg::CMD_LOAD;
	lcch_pkg::idx_t                 centroid_slot = '0;
	lcch_pkg::comp_t                centroid_l = '0;
	lcch_pkg::comp_t                centroid_a = '0;
	lcch_pkg::comp_t                centroid_b = '0;
	logic [lcch_pkg::PIX_W-1:0]     pixel_l = '0;
	logic [lcch_pkg::PIX_W-1:0]     pixel_a = '0;
	logic [lcch_pkg::PIX_W-1:0]     pixel_b = '0;
	logic                           bin_valid;
	logic                           bin_stall = 1'b0;
	lcch_pkg::idx_t                 bin_index;
	logic [lcch_pkg::BIN_CNT_W-1:0] bin_count;
	logic                           last_bin;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [lcch_pkg::SIDE_W-1:0]    cfg_data = '0;

	logic                           hold_req = 1'b0;
	bit                             steady = 1'b0;
	int                             burst_left = 0;
	int                             cycles = 0;
	cell_hist_board                 sb;

	lab_centroid_cell_histogram_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (cmd),
		.centroid_slot (centroid_slot),
		.centroid_l    (centroid_l),
		.centroid_a    (centroid_a),
		.centroid_b    (centroid_b),
		.pixel_l       (pixel_l),
		.pixel_a       (pixel_a),
		.pixel_b       (pixel_b),
		.bin_valid     (bin_valid),
		.bin_stall     (bin_stall),
		.bin_index     (bin_index),
		.bin_count     (bin_count),
		.last_bin      (last_bin),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (bin_valid && !bin_stall) begin
				sb.check_bin(bin_index, bin_count, last_bin);
			end
			if (cfg_valid && cfg_ready) begin
				sb.set_side(cfg_data);
			end
			if (item_valid && !item_stall) begin
				sb.note_word(cmd, centroid_slot, centroid_l, centroid_a, centroid_b,
					pixel_l, pixel_a, pixel_b);
			end
		end
	end

	// receiver: random stall stretches, one long hold-off on request
	initial begin
		bit hold_done;
		int mode;
		int len;
		hold_done = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				bin_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len  = $urandom_range(1, 40);
				repeat (len) begin
					case (mode)
						0: bin_stall <= 1'b0;
						1: bin_stall <= ($urandom_range(0, 2) == 0);
						default: bin_stall <= ($urandom_range(0, 3) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	task automatic drive_word(lcch_pkg::cmd_t c, lcch_pkg::idx_t slot,
			lcch_pkg::comp_t cl, lcch_pkg::comp_t ca, lcch_pkg::comp_t cb,
			logic [lcch_pkg::PIX_W-1:0] pl, logic [lcch_pkg::PIX_W-1:0] pa,
			logic [lcch_pkg::PIX_W-1:0] pb);
		if (!steady && burst_left == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = $urandom_range(1, 30);
		end
		item_valid    <= 1'b1;
		cmd           <= c;
		centroid_slot <= slot;
		centroid_l    <= cl;
		centroid_a    <= ca;
		centroid_b    <= cb;
		pixel_l       <= pl;
		pixel_a       <= pa;
		pixel_b       <= pb;
		do @(posedge clk); while (item_stall);
		if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic send_pixel();
		drive_word(lcch_pkg::CMD_PIXEL, lcch_pkg::idx_t'($urandom_range(0, 15)),
			lcch_pkg::comp_t'($urandom), lcch_pkg::comp_t'($urandom),
			lcch_pkg::comp_t'($urandom), lcch_pkg::PIX_W'($urandom),
			lcch_pkg::PIX_W'($urandom), lcch_pkg::PIX_W'($urandom));
	endtask

	function automatic lcch_pkg::comp_t pick_comp();
		return ($urandom_range(0, 3) == 0) ?
			lcch_pkg::comp_t'($urandom_range(0, 255) << lcch_pkg::FRAC_W)
			: lcch_pkg::comp_t'($urandom);
	endfunction

	task automatic send_load();
		drive_word(lcch_pkg::CMD_LOAD, lcch_pkg::idx_t'($urandom_range(0, 15)),
			pick_comp(), pick_comp(), pick_comp(), lcch_pkg::PIX_W'($urandom),
			lcch_pkg::PIX_W'($urandom), lcch_pkg::PIX_W'($urandom));
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic start_phase(logic [lcch_pkg::SIDE_W-1:0] v);
		drain();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [lcch_pkg::SIDE_W-1:0] v, int n_pix, bit press);
		start_phase(v);
		steady = press;
		if (press) begin
			hold_req <= 1'b1;
		end
		for (int i = 0; i < n_pix; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				send_load();
			end
			send_pixel();
		end
		steady = 1'b0;
	endtask

	task automatic directed_part();
		lcch_pkg::comp_t l, a, b;
		start_phase(lcch_pkg::SIDE_W'(1));
		for (int k = 0; k < lcch_pkg::NUM_CENTROIDS; k++) begin
			case (k)
				0: begin
					l = '0; a = '0; b = '0;
				end
				2, 7: begin
					l = 12'h400; a = 12'h400; b = 12'h400;
				end
				3: begin
					l = 12'h600; a = 12'h500; b = 12'h500;
				end
				4: begin
					l = 12'h600; a = 12'h700; b = 12'h500;
				end
				lcch_pkg::NUM_CENTROIDS - 1: begin
					l = '1; a = '1; b = '1;
				end
				default: begin
					l = lcch_pkg::comp_t'(k * 290);
					a = lcch_pkg::comp_t'(4095 - k * 290);
					b = lcch_pkg::comp_t'((k * 613) % 4096);
				end
			endcase
			drive_word(lcch_pkg::CMD_LOAD, lcch_pkg::IDX_W'(k), l, a, b, '0, '0, '0);
		end
		// out-of-range slot: drop
		drive_word(lcch_pkg::CMD_LOAD, lcch_pkg::idx_t'(15), 12'h123, 12'h456, 12'h789,
			'1, '1, '1);
		drive_word(lcch_pkg::CMD_PIXEL, '0, '1, '1, '1, 8'd0, 8'd0, 8'd0);
		drive_word(lcch_pkg::CMD_PIXEL, '1, '0, '0, '0, 8'd255, 8'd255, 8'd255);
		drive_word(lcch_pkg::CMD_PIXEL, '0, '0, '0, '0, 8'd64, 8'd64, 8'd64);
		drive_word(lcch_pkg::CMD_PIXEL, '0, '0, '0, '0, 8'h60, 8'h60, 8'h50);
		drive_word(lcch_pkg::CMD_PIXEL, '0, '0, '0, '0, 8'd255, 8'd0, 8'd128);
		drive_word(lcch_pkg::CMD_PIXEL, '0, '0, '0, '0, 8'd1, 8'd254, 8'd127);
	endtask

	initial begin
		sb = new();
		wait (arst_n);
		@(posedge clk);
		directed_part();
		run_phase(lcch_pkg::SIDE_W'(2), 8, 1'b0);
		run_phase(lcch_pkg::SIDE_W'(0), 4, 1'b0);
		run_phase(lcch_pkg::SIDE_W'(3), 12, 1'b0);
		run_phase(lcch_pkg::SIDE_W'(15), 3, 1'b0);
		run_phase(lcch_pkg::SIDE_W'(1), 10, 1'b1);
		run_phase(lcch_pkg::SIDE_W'(8), 64, 1'b0);
		run_phase(lcch_pkg::SIDE_W'(4), 9, 1'b0);
		run_phase(lcch_pkg::SIDE_W'($urandom_range(0, 3)), $urandom_range(4, 12), 1'b0);
		drain();
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/lcch_pkg.sv
src/lcch_front.sv
src/lcch_queue.sv
src/lcch_back.sv
src/lab_centroid_cell_histogram_top.sv
src/lcch_checker.sv
dv/tb_top.sv
